// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/atsc_pkg.sv
// Package: types and constants of the antenna tune sweep calibrator.
package atsc_pkg;

	localparam int REG_W  = 24;
	localparam int TUNE_W = 4;
	localparam int IDX_W  = 2;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_TARGET = 2'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW = 2'd1;
	localparam logic [IDX_W-1:0] REG_SETTLE = 2'd2;
	localparam logic [IDX_W-1:0] REG_TOL    = 2'd3;

	// Register reset values
	localparam logic [REG_W-1:0] TARGET_RST = 24'd3125;
	localparam logic [REG_W-1:0] WINDOW_RST = 24'd100000;
	localparam logic [REG_W-1:0] SETTLE_RST = 24'd2000;
	localparam logic [REG_W-1:0] TOL_RST    = 24'd109;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_SETTLE = 2'd1,
		PH_COUNT  = 2'd2,
		PH_FINAL  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [REG_W-1:0] target_count;
		logic [REG_W-1:0] window_ticks;
		logic [REG_W-1:0] settle_ticks;
		logic [REG_W-1:0] tolerance;
	} cfg_t;

	typedef struct packed {
		logic [TUNE_W-1:0] tune_value;
		logic              show_oscillator;
		logic              busy_res;
		logic              done_res;
		logic              pass;
		logic [REG_W-1:0]  best_error;
	} res_t;

endpackage

// File: rtl/core/atsc_step.sv
// Sweep state machine: updates calibration state for one sample tick.
module atsc_step #(
	parameter int TUNE_STEPS  = 16,
	parameter int COUNT_WIDTH = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          start_req,
	input  logic          irq_level,
	input  atsc_pkg::cfg_t cfg,
	output atsc_pkg::res_t res
);

	localparam int DW = ((COUNT_WIDTH > atsc_pkg::REG_W) ? COUNT_WIDTH : atsc_pkg::REG_W) + 1;
	localparam logic [atsc_pkg::TUNE_W-1:0] LAST_IDX = atsc_pkg::TUNE_W'(TUNE_STEPS - 1);

	atsc_pkg::phase_t                 phase_q, phase_n;
	logic [atsc_pkg::REG_W-1:0]       tick_q, tick_n, tick_inc;
	logic [atsc_pkg::TUNE_W-1:0]      idx_q, idx_n;
	logic [COUNT_WIDTH-1:0]           edge_q, edge_n;
	logic                             last_q, last_n;
	logic [atsc_pkg::REG_W-1:0]       best_q, best_n;
	logic [atsc_pkg::TUNE_W-1:0]      btune_q, btune_n;
	logic                             pass_q, pass_n;
	logic                             done;
	logic [DW-1:0]                    t_ext, e_ext, diff;
	logic [atsc_pkg::REG_W-1:0]       diff_sat;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= atsc_pkg::PH_IDLE;
			tick_q  <= '0;
			idx_q   <= '0;
			edge_q  <= '0;
			last_q  <= 1'b0;
			best_q  <= '1;
			btune_q <= '0;
			pass_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			idx_q   <= idx_n;
			edge_q  <= edge_n;
			last_q  <= last_n;
			best_q  <= best_n;
			btune_q <= btune_n;
			pass_q  <= pass_n;
		end
	end

	assign tick_inc = tick_q + 1'b1;

	// Absolute error of the count just finished, saturated to register width
	assign t_ext    = DW'(cfg.target_count);
	assign e_ext    = DW'(edge_n);
	assign diff     = (t_ext >= e_ext) ? (t_ext - e_ext) : (e_ext - t_ext);
	assign diff_sat = (|diff[DW-1:atsc_pkg::REG_W]) ? '1 : diff[atsc_pkg::REG_W-1:0];

	// Next state
	always_comb begin
		phase_n = phase_q;
		tick_n  = tick_q;
		idx_n   = idx_q;
		edge_n  = edge_q;
		last_n  = last_q;
		best_n  = best_q;
		btune_n = btune_q;
		pass_n  = pass_q;
		done    = 1'b0;
		case (phase_q)
			atsc_pkg::PH_IDLE: begin
				if (start_req) begin
					phase_n = atsc_pkg::PH_SETTLE;
					tick_n  = '0;
					idx_n   = '0;
					best_n  = '1;
					btune_n = '0;
				end
			end
			atsc_pkg::PH_SETTLE: begin
				if (tick_q >= cfg.settle_ticks) begin
					phase_n = atsc_pkg::PH_COUNT;
					tick_n  = '0;
					edge_n  = '0;
					last_n  = irq_level;
				end else begin
					tick_n = tick_inc;
				end
			end
			atsc_pkg::PH_COUNT: begin
				if (irq_level && !last_q && !(&edge_q))
					edge_n = edge_q + 1'b1;
				last_n = irq_level;
				tick_n = tick_inc;
				if (tick_inc >= cfg.window_ticks) begin
					if (diff_sat < best_q) begin
						best_n  = diff_sat;
						btune_n = idx_q;
					end
					tick_n = '0;
					if (idx_q >= LAST_IDX) begin
						phase_n = atsc_pkg::PH_FINAL;
					end else begin
						idx_n   = idx_q + 1'b1;
						phase_n = atsc_pkg::PH_SETTLE;
					end
				end
			end
			default: begin
				if (tick_q >= cfg.settle_ticks) begin
					phase_n = atsc_pkg::PH_IDLE;
					tick_n  = '0;
					done    = 1'b1;
					pass_n  = (best_q <= cfg.tolerance);
				end else begin
					tick_n = tick_inc;
				end
			end
		endcase
	end

	// Result reflects the state after this tick
	always_comb begin
		res.tune_value      = (phase_n == atsc_pkg::PH_SETTLE || phase_n == atsc_pkg::PH_COUNT)
			? idx_n : btune_n;
		res.show_oscillator = (phase_n != atsc_pkg::PH_IDLE);
		res.busy_res        = (phase_n != atsc_pkg::PH_IDLE);
		res.done_res        = done;
		res.pass            = pass_n;
		res.best_error      = best_n;
	end

endmodule

// File: rtl/core/antenna_tune_sweep_calibrator.sv
// Top level: antenna tune sweep calibrator with stream ports and register writes.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: start_req, irq_level
//  m_      | out | m_tvalid/m_tready  | m_tdata: tune/status/best_error, m_tlast: done
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// One request per cycle while s_tready is high; each request gives one result
// (input register, then sweep update into the output register).
// A two-entry output buffer keeps input flowing while a result waits.
// s_tready drops only when both output entries are full.
// arst_n clears control state and loads the register reset values.
module antenna_tune_sweep_calibrator #(
	parameter int TUNE_STEPS  = 16,
	parameter int COUNT_WIDTH = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [0] start_req, [1] irq_level
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,   // [3:0] tune_value, [4] show_oscillator,
	                                                // [5] busy_res, [6] pass, [30:7] best_error
	output logic                         m_tlast,   // done_res
	input  logic                         cfg_we,
	input  logic [atsc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [atsc_pkg::REG_W-1:0]   cfg_data
);

	atsc_pkg::cfg_t cfg_q;
	atsc_pkg::res_t res, out_q, skid_q;
	logic           valid_s1, start_s1, level_s1;
	logic           out_valid_q, skid_valid_q;
	logic           adv, push, pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_count <= atsc_pkg::TARGET_RST;
			cfg_q.window_ticks <= atsc_pkg::WINDOW_RST;
			cfg_q.settle_ticks <= atsc_pkg::SETTLE_RST;
			cfg_q.tolerance    <= atsc_pkg::TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				atsc_pkg::REG_TARGET: cfg_q.target_count <= cfg_data;
				atsc_pkg::REG_WINDOW: cfg_q.window_ticks <= cfg_data;
				atsc_pkg::REG_SETTLE: cfg_q.settle_ticks <= cfg_data;
				atsc_pkg::REG_TOL:    cfg_q.tolerance    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	assign adv      = valid_s1 && !skid_valid_q;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			start_s1 <= s_tdata[0];
			level_s1 <= s_tdata[1];
		end
	end

	atsc_step #(
		.TUNE_STEPS  (TUNE_STEPS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.start_req (start_s1),
		.irq_level (level_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	// Two-entry output buffer: head drives the port, skid catches stalls
	assign push = adv;
	assign pop  = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			case ({push, pop})
				2'b11: ;
				2'b01: begin
					out_valid_q  <= skid_valid_q;
					skid_valid_q <= 1'b0;
				end
				2'b10: begin
					if (out_valid_q)
						skid_valid_q <= 1'b1;
					else
						out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (pop) begin
			out_q <= skid_q;
		end else if (push) begin
			if (out_valid_q)
				skid_q <= res;
			else
				out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.best_error, out_q.pass, out_q.busy_res,
		out_q.show_oscillator, out_q.tune_value};
	assign m_tlast  = out_q.done_res;

endmodule

// File: rtl/core/atsc_checker.sv
// Port checker for the calibrator and its bind to the top level.
`include "assert_macros.svh"

module atsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// Done is reported on the tick that returns to idle
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, m_tvalid && m_tlast, !m_tdata[5])
	// Oscillator routing follows the busy status
	`ASSERT_IMPLIES(a_show_busy, clk, arst_n, m_tvalid, m_tdata[4] == m_tdata[5])
	// A stalled result stays offered
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// A stalled result keeps its data
	`ASSERT_NEXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready,
		$stable(m_tdata) && $stable(m_tlast))

endmodule

bind antenna_tune_sweep_calibrator atsc_checker u_atsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// File: dv/tb_antenna_tune_sweep_calibrator.sv
// Testbench for the antenna tune sweep calibrator: directed table, random sweeps, status check.
module tb_antenna_tune_sweep_calibrator;

	localparam int SWEEP_STEPS  = 16;
	localparam int COUNT_W      = 24;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 8;
	localparam logic [atsc_pkg::REG_W-1:0] ALL_ONES = {atsc_pkg::REG_W{1'b1}};
	localparam logic [atsc_pkg::REG_W-1:0] EDGE_TOP = {COUNT_W{1'b1}};

	// Directed plan: plain tick, tick with typed-in status, register write
	typedef enum logic [1:0] {
		ROW_TICK  = 2'd0,
		ROW_TYPED = 2'd1,
		ROW_WRITE = 2'd2
	} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [atsc_pkg::IDX_W-1:0]  idx;
		logic [atsc_pkg::REG_W-1:0]  data;
		logic                        start;
		logic                        level;
		atsc_pkg::res_t              want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [7:0] s_tdata = 8'd0;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [atsc_pkg::IDX_W-1:0] cfg_index = atsc_pkg::REG_TARGET;
	logic [atsc_pkg::REG_W-1:0] cfg_data = '0;
	wire s_tready;
	wire m_tvalid;
	wire [31:0] m_tdata;
	wire m_tlast;

	// Sweep predictor state
	atsc_pkg::cfg_t cal_regs;
	atsc_pkg::phase_t sw_phase;
	logic [atsc_pkg::REG_W-1:0] sw_ticks;
	logic [atsc_pkg::REG_W-1:0] sw_edges;
	logic [atsc_pkg::REG_W-1:0] sw_best_err;
	logic [atsc_pkg::TUNE_W-1:0] sw_tune;
	logic [atsc_pkg::TUNE_W-1:0] sw_best_tune;
	logic sw_last_lvl;
	logic sw_pass;

	atsc_pkg::res_t status_due[$];
	plan_row_t plan[$];
	int mismatches = 0;
	int cycles = 0;
	int hold_left = 0;
	bit calm = 1'b0;

	antenna_tune_sweep_calibrator #(
		.TUNE_STEPS(SWEEP_STEPS),
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic atsc_pkg::res_t status(input logic [atsc_pkg::TUNE_W-1:0] tune,
			input bit active, input bit done, input bit pass,
			input logic [atsc_pkg::REG_W-1:0] err);
		atsc_pkg::res_t r;
		r.tune_value      = tune;
		r.show_oscillator = active;
		r.busy_res        = active;
		r.done_res        = done;
		r.pass            = pass;
		r.best_error      = err;
		return r;
	endfunction

	function automatic plan_row_t tick_row(input bit start, input bit level);
		plan_row_t r;
		r = '0;
		r.kind  = ROW_TICK;
		r.start = start;
		r.level = level;
		return r;
	endfunction

	function automatic plan_row_t typed_row(input bit start, input bit level,
			input atsc_pkg::res_t want);
		plan_row_t r;
		r = tick_row(start, level);
		r.kind = ROW_TYPED;
		r.want = want;
		return r;
	endfunction

	function automatic plan_row_t write_row(input logic [atsc_pkg::IDX_W-1:0] idx,
			input logic [atsc_pkg::REG_W-1:0] data);
		plan_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx  = idx;
		r.data = data;
		return r;
	endfunction

	// Advance the sweep by one sample tick and return the status it shows
	function atsc_pkg::res_t sweep_tick(input bit start, input bit level);
		logic [atsc_pkg::REG_W-1:0] err;
		bit done;
		done = 1'b0;
		case (sw_phase)
			atsc_pkg::PH_IDLE: begin
				if (start) begin
					sw_phase     = atsc_pkg::PH_SETTLE;
					sw_ticks     = '0;
					sw_tune      = '0;
					sw_best_err  = ALL_ONES;
					sw_best_tune = '0;
				end
			end
			atsc_pkg::PH_SETTLE: begin
				if (sw_ticks >= cal_regs.settle_ticks) begin
					sw_phase    = atsc_pkg::PH_COUNT;
					sw_ticks    = '0;
					sw_edges    = '0;
					sw_last_lvl = level;
				end else begin
					sw_ticks = sw_ticks + 1'b1;
				end
			end
			atsc_pkg::PH_COUNT: begin
				if (level && !sw_last_lvl && sw_edges < EDGE_TOP)
					sw_edges = sw_edges + 1'b1;
				sw_last_lvl = level;
				sw_ticks = sw_ticks + 1'b1;
				// a zero window ends after one tick, same as a window of one
				if (sw_ticks >= cal_regs.window_ticks) begin
					err = (cal_regs.target_count >= sw_edges) ?
						cal_regs.target_count - sw_edges : sw_edges - cal_regs.target_count;
					// strict compare: earliest tune wins ties, all-ones never replaces
					if (err < sw_best_err) begin
						sw_best_err  = err;
						sw_best_tune = sw_tune;
					end
					sw_ticks = '0;
					if (sw_tune == atsc_pkg::TUNE_W'(SWEEP_STEPS - 1)) begin
						sw_phase = atsc_pkg::PH_FINAL;
					end else begin
						sw_tune  = sw_tune + 1'b1;
						sw_phase = atsc_pkg::PH_SETTLE;
					end
				end
			end
			default: begin
				if (sw_ticks >= cal_regs.settle_ticks) begin
					sw_phase = atsc_pkg::PH_IDLE;
					sw_ticks = '0;
					done     = 1'b1;
					sw_pass  = (sw_best_err <= cal_regs.tolerance);
				end else begin
					sw_ticks = sw_ticks + 1'b1;
				end
			end
		endcase
		return status((sw_phase == atsc_pkg::PH_SETTLE || sw_phase == atsc_pkg::PH_COUNT) ?
			sw_tune : sw_best_tune,
			sw_phase != atsc_pkg::PH_IDLE, done, sw_pass, sw_best_err);
	endfunction

	function void match_field(input string name, input logic [atsc_pkg::REG_W-1:0] want,
			input logic [atsc_pkg::REG_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one tick; a random gap may come first
	task send_tick(input bit start, input bit level, input bit typed,
			input atsc_pkg::res_t want);
		int gap;
		atsc_pkg::res_t pred;
		if (!calm && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, level, start};
		do @(posedge clk); while (!s_tready);
		pred = sweep_tick(start, level);
		status_due.push_back(typed ? want : pred);
	endtask

	// Register write once every pending status has come back
	task write_reg(input logic [atsc_pkg::IDX_W-1:0] idx,
			input logic [atsc_pkg::REG_W-1:0] data);
		s_tvalid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			atsc_pkg::REG_TARGET: cal_regs.target_count = data;
			atsc_pkg::REG_WINDOW: cal_regs.window_ticks = data;
			atsc_pkg::REG_SETTLE: cal_regs.settle_ticks = data;
			default:              cal_regs.tolerance    = data;
		endcase
		@(posedge clk);
	endtask

	// Status receiver with random stall bursts
	always @(posedge clk) begin : status_rx
		atsc_pkg::res_t got;
		atsc_pkg::res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.tune_value      = m_tdata[3:0];
				got.show_oscillator = m_tdata[4];
				got.busy_res        = m_tdata[5];
				got.pass            = m_tdata[6];
				got.best_error      = m_tdata[30:7];
				got.done_res        = m_tlast;
				if (status_due.size() == 0) begin
					$display("%0t: status with nothing pending, expected none got %h", $time, got);
					mismatches++;
				end else begin
					want = status_due.pop_front();
					match_field("tune_value", atsc_pkg::REG_W'(want.tune_value),
						atsc_pkg::REG_W'(got.tune_value));
					match_field("show_oscillator", atsc_pkg::REG_W'(want.show_oscillator),
						atsc_pkg::REG_W'(got.show_oscillator));
					match_field("busy_res", atsc_pkg::REG_W'(want.busy_res),
						atsc_pkg::REG_W'(got.busy_res));
					match_field("done_res", atsc_pkg::REG_W'(want.done_res),
						atsc_pkg::REG_W'(got.done_res));
					match_field("pass", atsc_pkg::REG_W'(want.pass),
						atsc_pkg::REG_W'(got.pass));
					match_field("best_error", want.best_error, got.best_error);
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int n;
		int mode;
		int ticks_sent;
		int win_eff;
		logic [atsc_pkg::REG_W-1:0] tgt;
		logic [atsc_pkg::REG_W-1:0] win;
		logic [atsc_pkg::REG_W-1:0] stl;
		logic [atsc_pkg::REG_W-1:0] tol;
		bit lvl;
		bit st;
		atsc_pkg::res_t idle_rst;
		atsc_pkg::res_t settle_0;

		cal_regs.target_count = atsc_pkg::TARGET_RST;
		cal_regs.window_ticks = atsc_pkg::WINDOW_RST;
		cal_regs.settle_ticks = atsc_pkg::SETTLE_RST;
		cal_regs.tolerance    = atsc_pkg::TOL_RST;
		sw_phase     = atsc_pkg::PH_IDLE;
		sw_ticks     = '0;
		sw_edges     = '0;
		sw_best_err  = ALL_ONES;
		sw_tune      = '0;
		sw_best_tune = '0;
		sw_last_lvl  = 1'b0;
		sw_pass      = 1'b0;
		ticks_sent   = 0;

		idle_rst = status(4'd0, 1'b0, 1'b0, 1'b0, ALL_ONES);
		settle_0 = status(4'd0, 1'b1, 1'b0, 1'b0, ALL_ONES);

		// idle after reset; then a sweep held by huge settle/window, released mid-sweep
		plan.push_back(typed_row(1'b0, 1'b0, idle_rst));
		plan.push_back(typed_row(1'b0, 1'b1, idle_rst));
		plan.push_back(write_row(atsc_pkg::REG_SETTLE, ALL_ONES));
		plan.push_back(write_row(atsc_pkg::REG_WINDOW, ALL_ONES));
		plan.push_back(write_row(atsc_pkg::REG_TARGET, '0));
		plan.push_back(write_row(atsc_pkg::REG_TOL, '0));
		// start tick ignores the pin; a second start while busy is ignored
		plan.push_back(typed_row(1'b1, 1'b1, settle_0));
		plan.push_back(typed_row(1'b1, 1'b0, settle_0));
		plan.push_back(tick_row(1'b0, 1'b1));
		plan.push_back(tick_row(1'b0, 1'b0));
		plan.push_back(write_row(atsc_pkg::REG_SETTLE, '0));
		plan.push_back(tick_row(1'b0, 1'b1));
		plan.push_back(tick_row(1'b0, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b1));
		plan.push_back(tick_row(1'b1, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b1));
		plan.push_back(tick_row(1'b0, 1'b1));
		// shrinking the window below the elapsed count closes it on the next tick
		plan.push_back(write_row(atsc_pkg::REG_WINDOW, 24'd1));
		plan.push_back(tick_row(1'b0, 1'b0));
		// zero window behaves as one tick
		plan.push_back(write_row(atsc_pkg::REG_WINDOW, '0));
		plan.push_back(tick_row(1'b0, 1'b1));
		plan.push_back(tick_row(1'b0, 1'b1));
		plan.push_back(tick_row(1'b0, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b1));
		plan.push_back(write_row(atsc_pkg::REG_TOL, ALL_ONES));
		plan.push_back(tick_row(1'b0, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b1));
		plan.push_back(tick_row(1'b1, 1'b1));
		plan.push_back(tick_row(1'b0, 1'b0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_tick(plan[i].start, plan[i].level, plan[i].kind == ROW_TYPED, plan[i].want);
		end

		// Random sweeps: fresh small settings each time, occasionally cut short
		while (ticks_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       tgt = ALL_ONES;
				1:       tgt = '0;
				default: tgt = atsc_pkg::REG_W'($urandom_range(0, 6));
			endcase
			win = ($urandom_range(0, 7) == 0) ? '0 : atsc_pkg::REG_W'($urandom_range(1, 5));
			stl = ($urandom_range(0, 5) == 0) ? atsc_pkg::REG_W'(3) :
				atsc_pkg::REG_W'($urandom_range(0, 2));
			tol = ($urandom_range(0, 7) == 0) ? ALL_ONES :
				atsc_pkg::REG_W'($urandom_range(0, 3));
			write_reg(atsc_pkg::REG_TARGET, tgt);
			write_reg(atsc_pkg::REG_WINDOW, win);
			write_reg(atsc_pkg::REG_SETTLE, stl);
			write_reg(atsc_pkg::REG_TOL, tol);

			win_eff = (win == 0) ? 1 : int'(win);
			mode = $urandom_range(0, 3);
			lvl = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 7) == 0)
				n = $urandom_range(1, 20);
			else
				n = SWEEP_STEPS * (int'(stl) + 1 + win_eff) + int'(stl) + 2 + $urandom_range(0, 5);

			for (int i = 0; i < n; i++) begin
				if (ticks_sent >= RANDOM_ITEMS * 17 / 20)
					calm = 1'b1;
				st = (i == 0) ? 1'b1 : ($urandom_range(0, 5) == 0);
				case (mode)
					0:       lvl = lvl;
					1:       lvl = 1'($urandom_range(0, 1));
					2:       lvl = ~lvl;
					default: lvl = ($urandom_range(0, 3) == 0) ? ~lvl : lvl;
				endcase
				send_tick(st, lvl, 1'b0, '0);
				ticks_sent++;
			end
		end

		s_tvalid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
